// ----- hdl/assert_macros.svh -----
// Assertion macros included by the tracker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hdl/ehf_pkg.sv -----
// Types and constants of the encoder frame health tracker.
package ehf_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRC,
        ST_EMA_A,
        ST_EMA_B,
        ST_DELTA,
        ST_RATE_MUL,
        ST_DIV_GO,
        ST_RATE_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        KIND_OOR,
        KIND_CLEAR,
        KIND_TRACKLOSS,
        KIND_CRCFAIL,
        KIND_GOOD
    } kind_t;

    localparam logic [1:0] HEALTH_OK       = 2'd0;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd1;
    localparam logic [1:0] HEALTH_FAULTED  = 2'd2;
    localparam logic [1:0] FIELD_NORMAL    = 2'd0;

    localparam logic       OP_FRAME = 1'b0;
    localparam logic       OP_CLEAR = 1'b1;

    localparam logic [1:0] CFG_ENC_USED = 2'd0;
    localparam logic [1:0] CFG_CRC_THR  = 2'd1;
    localparam logic [1:0] CFG_WEIGHT   = 2'd2;

    localparam logic [2:0] ENC_USED_DEFAULT = 3'd4;
    localparam logic [7:0] THR_DEFAULT      = 8'd10;
    localparam logic [8:0] WEIGHT_DEFAULT   = 9'd102;
    localparam logic [8:0] WEIGHT_ONE       = 9'd256;

    localparam logic [5:0] CRC_POLY      = 6'h03;
    localparam logic [4:0] CRC_LAST_BIT  = 5'd17;

    localparam logic [23:0] HALF_TURN_Q = 24'd2097152;
    localparam logic [23:0] TURN_Q      = 24'd4194304;
    localparam logic [19:0] US_PER_S    = 20'd1000000;
    localparam logic [31:0] MIN_READS   = 32'd100;
    localparam logic [31:0] EMA_ROUND   = 32'd128;

    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 28;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

// ----- hdl/ehf_div.sv -----
// Bit-serial restoring divider for the velocity quotient.
module ehf_div
    import ehf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  div_req_t             req,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output div_rsp_t             rsp,
    output logic [DIV_NUM_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            // one quotient bit per cycle
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/encoder_frame_health_tracker.sv -----
// Top level of the encoder frame health tracker.
// One item is worked on at a time. A clear or an item for an encoder out of
// use goes straight to the finish state; a frame with track loss or a CRC error
// ends after the CRC6 check, which shifts the 18 covered frame bits one per
// cycle; a good frame whose time step lies between 1 and 999999 us then passes
// the EMA, delta and rate steps and the one-bit-per-cycle divider that forms
// the velocity, otherwise it ends after the EMA and delta steps. The next item
// is taken as soon as the result sits in the output register, even while it waits to be taken.
`include "assert_macros.svh"

module encoder_frame_health_tracker
    import ehf_pkg::*;
#(
    parameter int ENCODER_COUNT = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [8:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [2:0]         s_encoder_index,
    input  logic [23:0]        s_frame_bits,
    input  logic [31:0]        s_timestamp_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_health_state,
    output logic               m_frame_good,
    output logic [21:0]        m_filtered_angle,
    output logic signed [33:0] m_angular_rate,
    output logic [1:0]         m_field_state
);

    localparam int IDX_W = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
    localparam logic [3:0] ENC_COUNT = 4'(ENCODER_COUNT);

    // configuration
    logic [2:0] enc_used_reg;
    logic [7:0] thr_reg;
    logic [8:0] weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_used_reg <= ENC_USED_DEFAULT;
            thr_reg      <= THR_DEFAULT;
            weight_reg   <= WEIGHT_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ENC_USED: enc_used_reg <= cfg_wdata[2:0];
                CFG_CRC_THR:  thr_reg      <= cfg_wdata[7:0];
                CFG_WEIGHT:   weight_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [3:0] used;
    logic [7:0] thr_eff;
    logic [8:0] w_eff;
    logic       in_range;

    assign used     = ({1'b0, enc_used_reg} > ENC_COUNT) ? ENC_COUNT : {1'b0, enc_used_reg};
    assign thr_eff  = (thr_reg == '0) ? THR_DEFAULT : thr_reg;
    assign w_eff    = (weight_reg == '0 || weight_reg > WEIGHT_ONE) ? WEIGHT_DEFAULT
                                                                    : weight_reg;
    assign in_range = {1'b0, s_encoder_index} < used;

    // per-encoder state
    logic [21:0] angle_store     [ENCODER_COUNT];
    logic [21:0] prev_angle_store[ENCODER_COUNT];
    logic [34:0] rate_store      [ENCODER_COUNT];
    logic [31:0] last_time_store [ENCODER_COUNT];
    logic [1:0]  health_store    [ENCODER_COUNT];
    logic [1:0]  field_store     [ENCODER_COUNT];
    logic [31:0] reads_store     [ENCODER_COUNT];
    logic [31:0] fails_store     [ENCODER_COUNT];
    logic [7:0]  run_store       [ENCODER_COUNT];

    state_t state_reg, state_next;
    kind_t  kind_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [23:0]      frame_reg;
    logic [31:0]      ts_reg;
    logic [17:0]      crc_sh_reg;
    logic [5:0]       crc_reg;
    logic [4:0]       crc_cnt_reg;
    logic [31:0]      acc_reg;
    logic [21:0]      mag_reg;
    logic             neg_reg;
    logic [19:0]      dt_reg;
    logic             err_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [34:0]      rate_new_reg;
    logic             rate_upd_reg;

    logic       m_valid_reg;
    logic [1:0] m_health_reg;
    logic       m_good_reg;
    logic [21:0] m_angle_reg;
    logic [33:0] m_rate_reg;
    logic [1:0] m_field_reg;

    logic     accept;
    logic     commit;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [DIV_NUM_W-1:0] quotient;

    assign accept = s_valid && s_ready;

    // bit-serial CRC6 step
    logic       crc_fb;
    logic [5:0] crc_next;
    logic       crc_bad;

    assign crc_fb   = crc_reg[5] ^ crc_sh_reg[17];
    assign crc_next = {crc_reg[4:0], 1'b0} ^ (crc_fb ? CRC_POLY : 6'd0);
    assign crc_bad  = crc_next != frame_reg[5:0];

    // shared EMA multiplier
    logic [8:0]  mul_a;
    logic [21:0] mul_b;
    logic [30:0] mul_prod;

    assign mul_a    = (state_reg == ST_EMA_A) ? w_eff : 9'(WEIGHT_ONE - w_eff);
    assign mul_b    = (state_reg == ST_EMA_A) ? {frame_reg[23:10], 8'd0} : angle_store[idx_reg];
    assign mul_prod = {22'd0, mul_a} * {9'd0, mul_b};

    // angle delta with half-turn wrap, elapsed time, error rate
    logic [21:0] angle_new;
    logic [23:0] delta_raw;
    logic [23:0] delta;
    logic [31:0] dt;
    logic        dt_ok;
    logic [31:0] reads_inc;
    logic [36:0] fails_x20;

    assign angle_new = acc_reg[29:8];
    assign delta_raw = {2'b0, angle_new} - {2'b0, prev_angle_store[idx_reg]};
    always_comb begin
        delta = delta_raw;
        if ($signed(delta_raw) > $signed(HALF_TURN_Q)) begin
            delta = delta_raw - TURN_Q;
        end else if ($signed(delta_raw) < -$signed(HALF_TURN_Q)) begin
            delta = delta_raw + TURN_Q;
        end
    end
    assign dt        = ts_reg - last_time_store[idx_reg];
    assign dt_ok     = dt != '0 && dt < {12'd0, US_PER_S};
    assign reads_inc = reads_store[idx_reg] + 1'b1;
    assign fails_x20 = {1'b0, fails_store[idx_reg], 4'd0}
                     + {3'b0, fails_store[idx_reg], 2'd0};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (!in_range || s_op == OP_CLEAR) ? ST_FINISH : ST_CRC;
                end
            end
            ST_CRC: begin
                if (crc_cnt_reg == CRC_LAST_BIT) begin
                    state_next = (frame_reg[6] || crc_bad) ? ST_FINISH : ST_EMA_A;
                end
            end
            ST_EMA_A:    state_next = ST_EMA_B;
            ST_EMA_B:    state_next = ST_DELTA;
            ST_DELTA:    state_next = dt_ok ? ST_RATE_MUL : ST_FINISH;
            ST_RATE_MUL: state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_RATE_DIV;
            ST_RATE_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready       = 1'b0;
        div_req.start = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready       = 1'b1;
            ST_DIV_GO: div_req.start = 1'b1;
            ST_FINISH: commit        = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_OOR;
            rate_upd_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg     <= !in_range ? KIND_OOR
                                      : (s_op == OP_CLEAR) ? KIND_CLEAR : KIND_GOOD;
                        rate_upd_reg <= 1'b0;
                    end
                end
                ST_CRC: begin
                    if (crc_cnt_reg == CRC_LAST_BIT) begin
                        kind_reg <= frame_reg[6] ? KIND_TRACKLOSS
                                  : crc_bad ? KIND_CRCFAIL : KIND_GOOD;
                    end
                end
                ST_RATE_DIV: begin
                    if (div_rsp.done) begin
                        rate_upd_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_reg     <= s_encoder_index[IDX_W-1:0];
                    frame_reg   <= s_frame_bits;
                    ts_reg      <= s_timestamp_us;
                    crc_sh_reg  <= s_frame_bits[23:6];
                    crc_reg     <= '0;
                    crc_cnt_reg <= '0;
                end
            end
            ST_CRC: begin
                crc_reg     <= crc_next;
                crc_sh_reg  <= {crc_sh_reg[16:0], 1'b0};
                crc_cnt_reg <= crc_cnt_reg + 1'b1;
            end
            ST_EMA_A: acc_reg <= EMA_ROUND + {1'b0, mul_prod};
            ST_EMA_B: acc_reg <= acc_reg + {1'b0, mul_prod};
            ST_DELTA: begin
                neg_reg <= delta[23];
                mag_reg <= delta[23] ? 22'(-delta) : delta[21:0];
                dt_reg  <= dt[19:0];
                err_reg <= reads_inc >= MIN_READS && fails_x20 > {5'd0, reads_inc};
            end
            ST_RATE_MUL: begin
                num_reg <= DIV_NUM_W'({20'd0, mag_reg} * {22'd0, US_PER_S})
                         + DIV_NUM_W'({dt_reg, 7'd0});
            end
            ST_RATE_DIV: begin
                if (div_rsp.done) begin
                    rate_new_reg <= neg_reg ? 35'(-quotient[34:0]) : quotient[34:0];
                end
            end
            default: ;
        endcase
    end

    ehf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .num      (num_reg),
        .den      ({dt_reg, 8'd0}),
        .rsp      (div_rsp),
        .quotient (quotient)
    );

    // store update for the item being finished
    logic [21:0] angle_nx, prev_nx;
    logic [34:0] rate_nx;
    logic [31:0] time_nx, reads_nx, fails_nx;
    logic [1:0]  health_nx, field_nx;
    logic [7:0]  run_nx, run_inc;
    logic        good_nx;

    assign run_inc = (run_store[idx_reg] == 8'hFF) ? 8'hFF : run_store[idx_reg] + 1'b1;

    always_comb begin
        angle_nx  = angle_store[idx_reg];
        prev_nx   = prev_angle_store[idx_reg];
        rate_nx   = rate_store[idx_reg];
        time_nx   = last_time_store[idx_reg];
        health_nx = health_store[idx_reg];
        field_nx  = field_store[idx_reg];
        reads_nx  = reads_store[idx_reg];
        fails_nx  = fails_store[idx_reg];
        run_nx    = run_store[idx_reg];
        good_nx   = 1'b0;
        case (kind_reg)
            KIND_CLEAR: begin
                health_nx = HEALTH_OK;
                reads_nx  = '0;
                fails_nx  = '0;
                run_nx    = '0;
            end
            KIND_TRACKLOSS: begin
                reads_nx  = reads_store[idx_reg] + 1'b1;
                field_nx  = frame_reg[9:8];
                health_nx = HEALTH_FAULTED;
            end
            KIND_CRCFAIL: begin
                reads_nx = reads_store[idx_reg] + 1'b1;
                fails_nx = fails_store[idx_reg] + 1'b1;
                field_nx = frame_reg[9:8];
                run_nx   = run_inc;
                if (run_inc >= thr_eff) begin
                    health_nx = HEALTH_FAULTED;
                end
            end
            KIND_GOOD: begin
                good_nx  = 1'b1;
                reads_nx = reads_store[idx_reg] + 1'b1;
                field_nx = frame_reg[9:8];
                run_nx   = '0;
                angle_nx = angle_new;
                prev_nx  = angle_new;
                time_nx  = ts_reg;
                if (rate_upd_reg) begin
                    rate_nx = rate_new_reg;
                end
                // faulted holds until a clear
                if (health_store[idx_reg] != HEALTH_FAULTED) begin
                    health_nx = (frame_reg[9:8] != FIELD_NORMAL || err_reg)
                              ? HEALTH_DEGRADED : HEALTH_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENCODER_COUNT; i++) begin
                angle_store[i]      <= '0;
                prev_angle_store[i] <= '0;
                rate_store[i]       <= '0;
                last_time_store[i]  <= '0;
                health_store[i]     <= HEALTH_OK;
                field_store[i]      <= FIELD_NORMAL;
                reads_store[i]      <= '0;
                fails_store[i]      <= '0;
                run_store[i]        <= '0;
            end
        end else if (commit && kind_reg != KIND_OOR) begin
            angle_store[idx_reg]      <= angle_nx;
            prev_angle_store[idx_reg] <= prev_nx;
            rate_store[idx_reg]       <= rate_nx;
            last_time_store[idx_reg]  <= time_nx;
            health_store[idx_reg]     <= health_nx;
            field_store[idx_reg]      <= field_nx;
            reads_store[idx_reg]      <= reads_nx;
            fails_store[idx_reg]      <= fails_nx;
            run_store[idx_reg]        <= run_nx;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (commit) begin
            if (kind_reg == KIND_OOR) begin
                m_health_reg <= HEALTH_FAULTED;
                m_good_reg   <= 1'b0;
                m_angle_reg  <= '0;
                m_rate_reg   <= '0;
                m_field_reg  <= FIELD_NORMAL;
            end else begin
                m_health_reg <= health_nx;
                m_good_reg   <= good_nx;
                m_angle_reg  <= angle_nx;
                m_rate_reg   <= rate_nx[33:0];
                m_field_reg  <= field_nx;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_health_state   = m_health_reg;
    assign m_frame_good     = m_good_reg;
    assign m_filtered_angle = m_angle_reg;
    assign m_angular_rate   = $signed(m_rate_reg);
    assign m_field_state    = m_field_reg;

    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE, "accepted item left block idle")
    `ASSERT_IMPLY(a_div_done_in_wait, aclk, aresetn, div_rsp.done, state_reg == ST_RATE_DIV, "divider finished outside divide wait")
    `ASSERT_NEXT(a_oor_faulted, aclk, aresetn, commit && kind_reg == KIND_OOR, m_health_state == HEALTH_FAULTED && !m_frame_good, "unused encoder not reported faulted")

endmodule

// ----- verif/encoder_frame_health_tracker_tb.sv -----
// Testbench for the encoder frame health tracker: random and directed frames checked against a predictor.
module encoder_frame_health_tracker_tb;
    import ehf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENC = 4;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]         health;
        logic               good;
        logic [21:0]        angle;
        logic signed [33:0] rate;
        logic [1:0]         field;
    } status_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [8:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = 1'b0;
    logic [2:0] s_encoder_index = '0;
    logic [23:0] s_frame_bits = '0;
    logic [31:0] s_timestamp_us = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_health_state;
    logic m_frame_good;
    logic [21:0] m_filtered_angle;
    logic signed [33:0] m_angular_rate;
    logic [1:0] m_field_state;

    encoder_frame_health_tracker #(.ENCODER_COUNT(NUM_ENC)) dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor copy of the block state
    logic [2:0] used_q;
    logic [7:0] thr_q;
    logic [8:0] weight_q;
    logic [21:0] ang_q [NUM_ENC];
    logic [21:0] prev_q [NUM_ENC];
    longint rate_q [NUM_ENC];
    logic [31:0] tlast_q [NUM_ENC];
    logic [1:0] health_q [NUM_ENC];
    logic [1:0] field_q [NUM_ENC];
    logic [31:0] reads_q [NUM_ENC];
    logic [31:0] fails_q [NUM_ENC];
    logic [7:0] run_q [NUM_ENC];

    status_t expected_status [$];
    int errors = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int idle_pct = 33;
    int stall_cycles = 0;
    logic [31:0] clock_us [NUM_ENC];

    function automatic logic [5:0] crc6(input logic [17:0] bits);
        logic [5:0] c;
        logic fb;
        c = '0;
        for (int i = 17; i >= 0; i--) begin
            fb = c[5] ^ bits[i];
            c = {c[4:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [23:0] good_frame(input logic [13:0] a, input logic [1:0] f,
                                               input logic b);
        logic [17:0] body;
        body = {a, f, b, 1'b0};
        return {body, crc6(body)};
    endfunction

    task automatic reset_model();
        used_q = ENC_USED_DEFAULT;
        thr_q = THR_DEFAULT;
        weight_q = WEIGHT_DEFAULT;
        for (int e = 0; e < NUM_ENC; e++) begin
            ang_q[e] = '0; prev_q[e] = '0; rate_q[e] = 0; tlast_q[e] = '0;
            health_q[e] = HEALTH_OK; field_q[e] = FIELD_NORMAL;
            reads_q[e] = '0; fails_q[e] = '0; run_q[e] = '0;
            clock_us[e] = '0;
        end
    endtask

    task automatic refresh_health(input int e);
        logic deg;
        if (health_q[e] == HEALTH_FAULTED) return;
        deg = field_q[e] != FIELD_NORMAL;
        if (reads_q[e] >= MIN_READS && 64'(fails_q[e]) * 20 > 64'(reads_q[e])) deg = 1'b1;
        health_q[e] = deg ? HEALTH_DEGRADED : HEALTH_OK;
    endtask

    task automatic predict_status(input logic op, input logic [2:0] idx, input logic [23:0] fr,
                                  input logic [31:0] now);
        status_t r;
        int e, used, thr, w;
        logic good;
        logic [31:0] dt;
        longint sum, delta, mag, den, q;
        used = (used_q > NUM_ENC) ? NUM_ENC : used_q;
        e = idx;
        good = 1'b0;
        if (e >= used) begin
            r = '0;
            r.health = HEALTH_FAULTED;
            expected_status.push_back(r);
            return;
        end
        if (op == OP_CLEAR) begin
            health_q[e] = HEALTH_OK; reads_q[e] = '0; fails_q[e] = '0; run_q[e] = '0;
        end else begin
            thr = (thr_q == 0) ? 10 : thr_q;
            w = (weight_q == 0 || weight_q > 256) ? 102 : weight_q;
            reads_q[e]++;
            field_q[e] = fr[9:8];
            if (fr[6]) begin
                health_q[e] = HEALTH_FAULTED;
            end else if (fr[5:0] != crc6(fr[23:6])) begin
                fails_q[e]++;
                if (run_q[e] < 255) run_q[e]++;
                if (run_q[e] >= thr) health_q[e] = HEALTH_FAULTED;
            end else begin
                good = 1'b1;
                run_q[e] = '0;
                sum = longint'(w) * (longint'(fr[23:10]) << 8)
                      + longint'(256 - w) * longint'(ang_q[e]) + 128;
                ang_q[e] = sum[29:8];
                dt = now - tlast_q[e];
                if (dt > 0 && dt < 1000000) begin
                    delta = longint'(ang_q[e]) - longint'(prev_q[e]);
                    if (delta > 2097152) delta -= 4194304;
                    else if (delta < -2097152) delta += 4194304;
                    mag = delta < 0 ? -delta : delta;
                    den = longint'(dt) * 256;
                    q = (mag * 1000000 + den / 2) / den;
                    rate_q[e] = delta < 0 ? -q : q;
                end
                prev_q[e] = ang_q[e];
                tlast_q[e] = now;
                refresh_health(e);
            end
        end
        r.health = health_q[e];
        r.good = good;
        r.angle = ang_q[e];
        r.rate = rate_q[e][33:0];
        r.field = field_q[e];
        expected_status.push_back(r);
    endtask

    // hold valid and payload until accepted; drop valid only while idling
    task automatic send_item(input logic op, input logic [2:0] idx, input logic [23:0] fr,
                             input logic [31:0] now);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        predict_status(op, idx, fr, now);
        s_valid <= 1'b1;
        s_op <= op;
        s_encoder_index <= idx;
        s_frame_bits <= fr;
        s_timestamp_us <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_ENC_USED: used_q = val[2:0];
            CFG_CRC_THR:  thr_q = val[7:0];
            CFG_WEIGHT:   weight_q = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // mostly good frames with small time steps so the rate path runs
    task automatic random_frame(input int enc_hi);
        logic [2:0] idx;
        logic [23:0] fr;
        int kind;
        idx = 3'($urandom_range(enc_hi));
        kind = $urandom_range(99);
        fr = good_frame(14'($urandom),
                        ($urandom_range(9) == 0) ? 2'($urandom) : FIELD_NORMAL,
                        1'($urandom));
        if (kind < 6) fr[6] = 1'b1;
        else if (kind < 14) fr[5:0] = fr[5:0] ^ 6'($urandom_range(1, 63));
        else if (kind < 16) fr = 24'($urandom);
        if (idx < NUM_ENC) begin
            case ($urandom_range(9))
                0: clock_us[idx] = clock_us[idx] + $urandom;
                1: clock_us[idx] = clock_us[idx];
                default: clock_us[idx] = clock_us[idx] + $urandom_range(1, 999999);
            endcase
            send_item((kind >= 98) ? OP_CLEAR : OP_FRAME, idx, fr, clock_us[idx]);
        end else begin
            send_item(1'($urandom), idx, fr, $urandom);
        end
    endtask

    task automatic test_directed();
        send_item(OP_FRAME, 3'd0, good_frame(14'h3FFF, 2'd0, 1'b1), 32'd1);
        send_item(OP_FRAME, 3'd0, good_frame(14'h0000, 2'd0, 1'b0), 32'd2);
        send_item(OP_FRAME, 3'd0, good_frame(14'h2000, 2'd3, 1'b0), 32'd1000001);
        send_item(OP_FRAME, 3'd0, good_frame(14'h1000, 2'd1, 1'b0), 32'hFFFF_FFFF);
        send_item(OP_FRAME, 3'd0, good_frame(14'h1000, 2'd2, 1'b0), 32'h0000_0000);
        send_item(OP_FRAME, 3'd1, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 3'd1, 24'h0, 32'h0);
        for (int i = 0; i < 11; i++)
            send_item(OP_FRAME, 3'd2, good_frame(14'h0123, 2'd0, 1'b0) ^ 24'h1, 32'(i));
        send_item(OP_FRAME, 3'd2, good_frame(14'h0123, 2'd0, 1'b0), 32'd50);
        send_item(OP_CLEAR, 3'd2, 24'h0, 32'h0);
        send_item(OP_FRAME, 3'd3, good_frame(14'h3FFF, 2'd0, 1'b0), 32'd999999);
        send_item(OP_FRAME, 3'd5, 24'hABCDEF, 32'd7);
        send_item(OP_CLEAR, 3'd7, 24'h0, 32'd0);
        drain();
    endtask

    task automatic test_configs();
        int used_vals [5] = '{1, 4, 0, 7, 3};
        int thr_vals [5] = '{1, 255, 0, 3, 10};
        int w_vals [5] = '{256, 1, 0, 511, 102};
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_ENC_USED, 9'(used_vals[p]));
            write_reg(CFG_CRC_THR, 9'(thr_vals[p]));
            write_reg(CFG_WEIGHT, 9'(w_vals[p]));
            idle_pct = (p == 1) ? 0 : 33;
            for (int i = 0; i < 160; i++) random_frame(i % 4 == 0 ? 7 : NUM_ENC - 1);
            drain();
        end
        idle_pct = 33;
    endtask

    // long runs per encoder to cross the 100-read error-rate window
    task automatic test_error_rate();
        write_reg(CFG_ENC_USED, 9'd4);
        write_reg(CFG_CRC_THR, 9'd255);
        write_reg(CFG_WEIGHT, 9'($urandom_range(1, 256)));
        for (int i = 0; i < 600; i++) random_frame(NUM_ENC - 1);
        drain();
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_configs();
        test_error_rate();
        $display("Sent %0d items (frames, clears, unused encoders) over several register settings;",
                 frames_sent);
        $display("checked %0d results with random idling on both sides.", results_seen);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        status_t exp_s;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                exp_s = expected_status.pop_front();
                if (m_health_state !== exp_s.health) begin
                    $error("health_state exp %0d got %0d", exp_s.health, m_health_state);
                    errors++;
                end
                if (m_frame_good !== exp_s.good) begin
                    $error("frame_good exp %0d got %0d", exp_s.good, m_frame_good);
                    errors++;
                end
                if (m_filtered_angle !== exp_s.angle) begin
                    $error("filtered_angle exp %0d got %0d", exp_s.angle, m_filtered_angle);
                    errors++;
                end
                if (m_angular_rate !== exp_s.rate) begin
                    $error("angular_rate exp %0d got %0d", exp_s.rate, m_angular_rate);
                    errors++;
                end
                if (m_field_state !== exp_s.field) begin
                    $error("field_state exp %0d got %0d", exp_s.field, m_field_state);
                    errors++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || expected_status.size() == 0)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end
endmodule
